// ===== sv/rhs_pkg.sv =====
package rhs_pkg;

    localparam int MAX_IN_WIDTH_DEF    = 2048;
    localparam int BYTES_PER_PIXEL_DEF = 3;

    localparam int CFG_W  = 12;
    localparam int DATA_W = 8;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(1200);

    // request handed from the counter stage to the averaging stage
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] pix;
        logic              last;
    } rhs_req_t;

endpackage

// ===== sv/rhs_ram.sv =====
module rhs_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 3072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rhs_ctrl.sv =====
module rhs_ctrl
    import rhs_pkg::*;
#(
    parameter int MAX_IN_WIDTH    = MAX_IN_WIDTH_DEF,
    parameter int BYTES_PER_PIXEL = BYTES_PER_PIXEL_DEF,
    localparam int DEPTH = (MAX_IN_WIDTH / 2) * BYTES_PER_PIXEL,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              accept,
    input  logic [DATA_W-1:0] pixel_byte,
    input  logic              frame_start,
    output logic              ram_we,
    output logic              ram_re,
    output logic [AW-1:0]     ram_addr,
    output rhs_req_t          req
);

    localparam int CW  = $clog2(MAX_IN_WIDTH);
    localparam int EW  = $clog2(MAX_IN_WIDTH + 1);
    localparam int XW  = (EW > CFG_W) ? EW : CFG_W;
    localparam int BW  = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;
    localparam int AXW = AW + 1;
    localparam logic [XW-1:0] MAX_EVEN = XW'(MAX_IN_WIDTH) & ~XW'(1);
    localparam logic [BW-1:0] LAST_BYTE = BW'(BYTES_PER_PIXEL - 1);

    logic [CFG_W-1:0] width_reg;
    logic [BW-1:0]    byte_reg, byte_next;
    logic [CW-1:0]    col_reg, col_next;
    logic             odd_reg, odd_next;

    logic [BW-1:0]  byte_cur;
    logic [CW-1:0]  col_cur;
    logic           odd_cur;
    logic [XW-1:0]  width_x;
    logic [EW-1:0]  eff_width;
    logic [EW-1:0]  col_inc;
    logic [AXW-1:0] addr_full;
    logic           in_range;
    logic           kept;

    // clamp to an even width within 2..MAX_IN_WIDTH
    always_comb
    begin
        width_x = XW'(width_reg) & ~XW'(1);
        if (width_x < XW'(2))
        begin
            width_x = XW'(2);
        end
        if (width_x > XW'(MAX_IN_WIDTH))
        begin
            width_x = MAX_EVEN;
        end
        eff_width = EW'(width_x);
    end

    assign byte_cur = frame_start ? '0 : byte_reg;
    assign col_cur  = frame_start ? '0 : col_reg;
    assign odd_cur  = frame_start ? 1'b0 : odd_reg;
    assign col_inc  = EW'(col_cur) + EW'(1);

    assign addr_full = AXW'(col_cur >> 1) * AXW'(BYTES_PER_PIXEL) + AXW'(byte_cur);
    assign in_range  = addr_full < AXW'(DEPTH);
    assign kept      = col_cur[0] & in_range;

    assign ram_addr = addr_full[AW-1:0];
    assign ram_we   = accept & kept & ~odd_cur;
    assign ram_re   = accept & kept & odd_cur;

    assign req.hit  = ram_re;
    assign req.pix  = pixel_byte;
    assign req.last = (col_inc == eff_width) && (byte_cur == LAST_BYTE);

    always_comb
    begin
        byte_next = byte_cur + BW'(1);
        col_next  = col_cur;
        odd_next  = odd_cur;
        if (byte_cur == LAST_BYTE)
        begin
            byte_next = '0;
            if (col_inc >= eff_width)
            begin
                col_next = '0;
                odd_next = ~odd_cur;
            end
            else
            begin
                col_next = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            byte_reg  <= '0;
            col_reg   <= '0;
            odd_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                width_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                byte_reg <= byte_next;
                col_reg  <= col_next;
                odd_reg  <= odd_next;
            end
        end
    end

endmodule

// ===== sv/rhs_avg.sv =====
module rhs_avg
    import rhs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rhs_req_t          req,
    input  logic [DATA_W-1:0] ram_rdata,
    output logic              take_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_byte,
    output logic              row_end
);

    logic              s1_valid_reg;
    logic [DATA_W-1:0] s1_pix_reg;
    logic              s1_last_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_byte_reg;
    logic              row_end_reg;

    logic              s1_adv;
    logic [DATA_W:0]   sum;

    assign s1_adv  = s1_valid_reg & (~out_valid_reg | out_ready);
    // stage 1 frees up this cycle when empty or when it moves on
    assign take_ok = ~s1_valid_reg | ~out_valid_reg | out_ready;

    // ram_rdata holds the stored byte for the beat in stage 1
    assign sum = {1'b0, ram_rdata} + {1'b0, s1_pix_reg} + (DATA_W+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_ok)
            begin
                s1_valid_reg <= req.hit;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_ok && req.hit)
        begin
            s1_pix_reg  <= req.pix;
            s1_last_reg <= req.last;
        end
        if (s1_adv)
        begin
            out_byte_reg <= sum[DATA_W:1];
            row_end_reg  <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign row_end   = row_end_reg;

endmodule

// ===== sv/rgb_half_scaler.sv =====
// Path from input beat to output beat: line buffer read, then average into the output register.
// Throughput: one input byte per cycle while in_ready is high; at most one line buffer access per byte sets that rate.
// in_ready drops only when the read stage and output register are full and out_ready is low.
// Reset (rst_n, async, active low) clears counters and valids and sets width to 1200.
// Line buffer contents are not cleared; entries are written before they are read.
module rgb_half_scaler
    import rhs_pkg::*;
#(
    parameter int MAX_IN_WIDTH    = MAX_IN_WIDTH_DEF,
    parameter int BYTES_PER_PIXEL = BYTES_PER_PIXEL_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] pixel_byte,
    input  logic              frame_start,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_byte,
    output logic              row_end
);

    localparam int DEPTH = (MAX_IN_WIDTH / 2) * BYTES_PER_PIXEL;
    localparam int AW    = $clog2(DEPTH);

    logic              accept;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_addr;
    logic [DATA_W-1:0] ram_rdata;
    rhs_req_t          req;

    assign accept = in_valid & in_ready;

    rhs_ctrl #(
        .MAX_IN_WIDTH    (MAX_IN_WIDTH),
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .pixel_byte  (pixel_byte),
        .frame_start (frame_start),
        .ram_we      (ram_we),
        .ram_re      (ram_re),
        .ram_addr    (ram_addr),
        .req         (req)
    );

    rhs_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (pixel_byte),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    rhs_avg u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ram_rdata (ram_rdata),
        .take_ok   (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .row_end   (row_end)
    );

endmodule
